// ===== src/flrl_pkg.sv =====
package flrl_pkg;

  // request kinds
  localparam logic [1:0] REQ_INIT  = 2'd0;
  localparam logic [1:0] REQ_SCAN  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_READ  = 2'd3;

  // flash commands
  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_ERASE   = 2'd1;
  localparam logic [1:0] CMD_PROGRAM = 2'd2;

  // configuration register indexes
  localparam logic CFG_FLASH_PRESENT = 1'b0;
  localparam logic CFG_TICK_ENABLED  = 1'b1;

  // erased flash word
  localparam logic [31:0] SEQ_EMPTY = 32'hFFFF_FFFF;

  localparam int REC_INDEX_W = 11;
  localparam int READ_POS_W  = 9;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [31:0]            flash_seq;
    logic [31:0]            stamp_ms;
    logic [7:0]             event_code;
    logic [7:0]             arg0;
    logic [7:0]             arg1;
    logic [7:0]             arg2;
    logic [READ_POS_W-1:0]  read_pos;
  } in_word_t;

  typedef struct packed {
    logic [1:0]             flash_cmd;
    logic [REC_INDEX_W-1:0] rec_index;
    logic [31:0]            out_seq;
    logic [31:0]            out_stamp;
    logic [7:0]             out_event;
    logic [7:0]             out_arg0;
    logic [7:0]             out_arg1;
    logic [7:0]             out_arg2;
    logic                   hit;
    logic                   scanning;
    logic                   last_item;
  } out_word_t;

  // one cached log record
  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] stamp;
    logic [7:0]  ev;
    logic [7:0]  a0;
    logic [7:0]  a1;
    logic [7:0]  a2;
  } cache_rec_t;

endpackage

// ===== src/flrl_ram.sv =====
module flrl_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read that holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/flash_ring_log_manager_top.sv =====
// A result word passes through the result stage and then the output register before it shows on out_valid.
// One request per cycle while the output does not stall; a write that also erases gives two words,
// paced by the single output register draining the result stage; in_stall holds new requests meanwhile.
// Cache reads use the registered read port of the cache RAM, issued at acceptance.
// Reset (rst, synchronous, active high) clears all control state and configuration;
// cache contents are not cleared, the fill count marks what is valid.
module flash_ring_log_manager_top
  import flrl_pkg::*;
#(
  parameter int RECORDS_PER_SECTOR = 128,
  parameter int SECTORS            = 16,
  parameter int CACHE_DEPTH        = 512
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic      cfg_data
);

  localparam int AREA    = RECORDS_PER_SECTOR * SECTORS;
  localparam int HOLE_W  = $clog2(AREA + 1);
  localparam int OFF_W   = $clog2(RECORDS_PER_SECTOR);
  localparam int CIDX_W  = $clog2(CACHE_DEPTH);
  localparam int CFILL_W = $clog2(CACHE_DEPTH + 1);
  localparam int CMP_W   = (CFILL_W > READ_POS_W) ? CFILL_W : READ_POS_W;

  // configuration
  logic flash_present, tick_enabled;

  // log state
  logic              ready, ready_next;
  logic              scan_active, scan_active_next;
  logic [HOLE_W-1:0] write_hole, write_hole_next;
  logic [OFF_W-1:0]  write_off, write_off_next;
  logic [31:0]       newest_seq, newest_seq_next;
  logic [HOLE_W-1:0] scan_pos, scan_pos_next;
  logic [OFF_W-1:0]  scan_off, scan_off_next;
  logic [HOLE_W-1:0] scan_base, scan_base_next;
  logic [CIDX_W-1:0]  cache_oldest, cache_oldest_next;
  logic [CFILL_W-1:0] cache_fill, cache_fill_next;

  // result stage and output register
  logic       s_valid, s_two, s_ram;
  out_word_t  s_w0, s_w1;
  logic       o_valid;
  out_word_t  o_word;

  // per-request decode
  logic        in_acc, s_move;
  out_word_t   w0, w1;
  logic        two, from_ram;
  logic        push, ram_re;
  cache_rec_t  rec;
  cache_rec_t  ram_rdata;
  logic [CIDX_W-1:0]  push_addr, rd_addr;
  logic [CFILL_W:0]   push_sum;
  logic [CMP_W:0]     rd_sum;
  logic               rd_hit;
  out_word_t          head;

  assign s_move   = s_valid & (~o_valid | ~out_stall);
  assign in_stall = s_valid & ~(s_move & ~s_two);
  assign in_acc   = in_valid & ~in_stall;

  // cache ring address arithmetic, sums stay below twice the depth
  assign push_sum = (CFILL_W + 1)'(cache_oldest) + (CFILL_W + 1)'(cache_fill);
  assign rd_sum   = (CMP_W + 1)'(cache_oldest) + (CMP_W + 1)'(in_word.read_pos);
  assign rd_hit   = CMP_W'(in_word.read_pos) < CMP_W'(cache_fill);

  always_comb begin
    if (push_sum >= (CFILL_W + 1)'(CACHE_DEPTH)) begin
      push_addr = CIDX_W'(push_sum - (CFILL_W + 1)'(CACHE_DEPTH));
    end else begin
      push_addr = CIDX_W'(push_sum);
    end
    if (rd_sum >= (CMP_W + 1)'(CACHE_DEPTH)) begin
      rd_addr = CIDX_W'(rd_sum - (CMP_W + 1)'(CACHE_DEPTH));
    end else begin
      rd_addr = CIDX_W'(rd_sum);
    end
  end

  // request decode and next state
  always_comb begin
    ready_next        = ready;
    scan_active_next  = scan_active;
    write_hole_next   = write_hole;
    write_off_next    = write_off;
    newest_seq_next   = newest_seq;
    scan_pos_next     = scan_pos;
    scan_off_next     = scan_off;
    scan_base_next    = scan_base;
    cache_oldest_next = cache_oldest;
    cache_fill_next   = cache_fill;
    w0       = '0;
    w1       = '0;
    two      = 1'b0;
    from_ram = 1'b0;
    push     = 1'b0;
    ram_re   = 1'b0;
    rec.seq   = in_word.flash_seq;
    rec.stamp = in_word.stamp_ms;
    rec.ev    = in_word.event_code;
    rec.a0    = in_word.arg0;
    rec.a1    = in_word.arg1;
    rec.a2    = in_word.arg2;
    w0.last_item = 1'b1;
    w1.last_item = 1'b1;

    unique case (in_word.req_type)
      REQ_INIT: begin
        if (!flash_present) begin
          ready_next       = 1'b0;
          scan_active_next = 1'b0;
        end else begin
          ready_next        = 1'b1;
          scan_active_next  = 1'b1;
          cache_oldest_next = '0;
          cache_fill_next   = '0;
          newest_seq_next   = '0;
          write_hole_next   = '0;
          write_off_next    = '0;
          scan_pos_next     = '0;
          scan_off_next     = '0;
          scan_base_next    = '0;
          w0.hit            = 1'b1;
        end
      end
      REQ_SCAN: begin
        if (ready && scan_active) begin
          w0.hit = 1'b1;
          if (in_word.flash_seq == SEQ_EMPTY) begin
            // first empty record is the hole
            write_hole_next  = scan_pos;
            write_off_next   = scan_off;
            scan_active_next = 1'b0;
          end else if (newest_seq != '0 && in_word.flash_seq != newest_seq + 32'd1) begin
            // sequence gap: hole here, erase its sector
            write_hole_next  = scan_pos;
            write_off_next   = scan_off;
            scan_active_next = 1'b0;
            w0.flash_cmd     = CMD_ERASE;
            w0.rec_index     = REC_INDEX_W'(scan_base);
          end else begin
            newest_seq_next = in_word.flash_seq;
            push            = 1'b1;
            scan_pos_next   = scan_pos + HOLE_W'(1);
            if (scan_off == OFF_W'(RECORDS_PER_SECTOR - 1)) begin
              scan_off_next  = '0;
              scan_base_next = scan_base + HOLE_W'(RECORDS_PER_SECTOR);
            end else begin
              scan_off_next = scan_off + OFF_W'(1);
            end
            // full contiguous area wraps to sector 0
            if (scan_pos == HOLE_W'(AREA - 1)) begin
              write_hole_next  = '0;
              write_off_next   = '0;
              scan_active_next = 1'b0;
              w0.flash_cmd     = CMD_ERASE;
            end
          end
        end
      end
      REQ_WRITE: begin
        if (ready && !scan_active) begin
          newest_seq_next = newest_seq + 32'd1;
          rec.seq         = newest_seq + 32'd1;
          if (!tick_enabled) begin
            rec.stamp = '0;
          end
          push = 1'b1;
          w1.flash_cmd = CMD_PROGRAM;
          w1.out_seq   = rec.seq;
          w1.out_stamp = rec.stamp;
          w1.out_event = rec.ev;
          w1.out_arg0  = rec.a0;
          w1.out_arg1  = rec.a1;
          w1.out_arg2  = rec.a2;
          w1.hit       = 1'b1;
          w1.rec_index = REC_INDEX_W'(write_hole);
          if (write_off == OFF_W'(RECORDS_PER_SECTOR - 1)) begin
            write_off_next = '0;
          end else begin
            write_off_next = write_off + OFF_W'(1);
          end
          write_hole_next = write_hole + HOLE_W'(1);
          if (write_hole == HOLE_W'(AREA)) begin
            // area end: erase sector 0, program record 0
            two             = 1'b1;
            w0.flash_cmd    = CMD_ERASE;
            w0.hit          = 1'b1;
            w0.last_item    = 1'b0;
            w1.rec_index    = '0;
            write_hole_next = HOLE_W'(1);
            write_off_next  = OFF_W'(1);
          end else if (write_hole != '0 && write_off == '0 &&
                       in_word.flash_seq != SEQ_EMPTY) begin
            // entering a used sector: erase it first
            two          = 1'b1;
            w0.flash_cmd = CMD_ERASE;
            w0.rec_index = REC_INDEX_W'(write_hole);
            w0.hit       = 1'b1;
            w0.last_item = 1'b0;
          end else begin
            w0 = w1;
          end
        end
      end
      REQ_READ: begin
        if (ready && !scan_active && rd_hit) begin
          ram_re   = 1'b1;
          from_ram = 1'b1;
          w0.hit   = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // ring push, overwrite the oldest when full
    if (push) begin
      if (cache_fill == CFILL_W'(CACHE_DEPTH)) begin
        if (cache_oldest == CIDX_W'(CACHE_DEPTH - 1)) begin
          cache_oldest_next = '0;
        end else begin
          cache_oldest_next = cache_oldest + CIDX_W'(1);
        end
      end else begin
        cache_fill_next = cache_fill + CFILL_W'(1);
      end
    end

    w0.scanning = scan_active_next;
    w1.scanning = scan_active_next;
  end

  // cache memory
  flrl_ram #(
    .WIDTH ($bits(cache_rec_t)),
    .DEPTH (CACHE_DEPTH)
  ) u_cache (
    .clk   (clk),
    .we    (in_acc & push),
    .waddr ((cache_fill == CFILL_W'(CACHE_DEPTH)) ? cache_oldest : push_addr),
    .wdata (rec),
    .re    (in_acc & ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      flash_present <= 1'b0;
      tick_enabled  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FLASH_PRESENT: flash_present <= cfg_data;
        CFG_TICK_ENABLED:  tick_enabled  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // state update on accepted requests
  always_ff @(posedge clk) begin
    if (rst) begin
      ready        <= 1'b0;
      scan_active  <= 1'b0;
      write_hole   <= '0;
      write_off    <= '0;
      newest_seq   <= '0;
      scan_pos     <= '0;
      scan_off     <= '0;
      scan_base    <= '0;
      cache_oldest <= '0;
      cache_fill   <= '0;
    end else if (in_acc) begin
      ready        <= ready_next;
      scan_active  <= scan_active_next;
      write_hole   <= write_hole_next;
      write_off    <= write_off_next;
      newest_seq   <= newest_seq_next;
      scan_pos     <= scan_pos_next;
      scan_off     <= scan_off_next;
      scan_base    <= scan_base_next;
      cache_oldest <= cache_oldest_next;
      cache_fill   <= cache_fill_next;
    end
  end

  // head word of the result stage, with cached record patched in
  always_comb begin
    head = s_w0;
    if (s_ram) begin
      head.out_seq   = ram_rdata.seq;
      head.out_stamp = ram_rdata.stamp;
      head.out_event = ram_rdata.ev;
      head.out_arg0  = ram_rdata.a0;
      head.out_arg1  = ram_rdata.a1;
      head.out_arg2  = ram_rdata.a2;
    end
  end

  // result stage: up to two words per request
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      s_two   <= 1'b0;
      s_ram   <= 1'b0;
    end else if (in_acc) begin
      s_valid <= 1'b1;
      s_two   <= two;
      s_ram   <= from_ram;
      s_w0    <= w0;
      s_w1    <= w1;
    end else if (s_move) begin
      if (s_two) begin
        s_w0  <= s_w1;
        s_two <= 1'b0;
        s_ram <= 1'b0;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s_move) begin
      o_valid <= 1'b1;
      o_word  <= head;
    end else if (o_valid && !out_stall) begin
      o_valid <= 1'b0;
    end
  end

  assign out_valid = o_valid;
  assign out_word  = o_word;

endmodule

// ===== src/flrl_checker.sv =====
module flrl_checker
  import flrl_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("output word changed while stalled");

  // a non-final word is followed at once by the program word that ends the request
  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_word.last_item |=>
      out_valid && out_word.flash_cmd == CMD_PROGRAM && out_word.last_item)
    else $error("erase not followed by its program word");

  // no flash command is issued while the scan is still running
  a_scan_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.scanning |-> out_word.flash_cmd == CMD_NONE)
    else $error("flash command during recovery scan");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind flash_ring_log_manager_top flrl_checker u_chk (.*);
